@@ rtl/core/twwc_pkg.sv @@
`timescale 1ns / 1ps

package twwc_pkg;

  // Largest wrap column, and so the depth of the word store
  localparam int unsigned MAX_COLUMN = 60;

  localparam int unsigned COL_W   = 6;   // column register width
  localparam int unsigned LINE_W  = 7;   // output column counter, wraps modulo 128
  localparam int unsigned BYTE_W  = 8;

  localparam logic [COL_W-1:0] COL_RESET = 6'd60;

  // Input queue between the front and the back
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
  localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;

  // One classified input beat
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              eot;
    logic              blank;
    logic              cr;
    logic              lf;
    logic              nul;
  } item_t;

  // Back to output stage: one byte per cycle while emit_ok allows, close ends the current step
  typedef struct packed {
    logic              emit;
    logic [BYTE_W-1:0] data;
    logic              close;
  } emit_req_t;

  // Output stage to back
  typedef struct packed {
    logic emit_ok;  // a byte may be emitted this cycle
    logic busy;     // last byte of a step still to be moved out
  } out_stat_t;

endpackage

@@ rtl/core/twwc_front.sv @@
`timescale 1ns / 1ps

module twwc_front import twwc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] in_byte
  input  logic              s_axis_tlast,   // end_of_text
  output item_t             head_o,
  output logic              head_v_o,
  input  logic              pop_i
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

  item_t           q_mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  item_t           cls;
  logic            push, pop;

  // classify
  always_comb begin
    cls.data  = s_axis_tdata;
    cls.eot   = s_axis_tlast;
    cls.blank = (s_axis_tdata inside {CH_SP, [CH_TAB:CH_CR]});
    cls.cr    = (s_axis_tdata == CH_CR);
    cls.lf    = (s_axis_tdata == CH_LF);
    cls.nul   = (s_axis_tdata == CH_NUL);
  end

  assign s_axis_tready = (cnt_q != CntW'(QUEUE_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign head_v_o      = (cnt_q != '0);
  assign pop           = pop_i && head_v_o;
  assign head_o        = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

@@ rtl/core/twwc_back.sv @@
`timescale 1ns / 1ps

module twwc_back import twwc_pkg::*; #(
  parameter int unsigned MaxColumn = MAX_COLUMN
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [COL_W-1:0] col_i,
  input  item_t            head_i,
  input  logic             head_v_i,
  output logic             pop_o,
  output emit_req_t        req_o,
  input  out_stat_t        stat_i
);

  localparam int unsigned WlW   = $clog2(MaxColumn + 1);
  localparam int unsigned AddrW = $clog2(MaxColumn);
  localparam logic [WlW-1:0] WlMax = WlW'(MaxColumn);

  localparam int unsigned MODE_W = 4;
  localparam logic [MODE_W-1:0] MODE_WS    = 4'd0;
  localparam logic [MODE_W-1:0] MODE_WS_CR = 4'd1;
  localparam logic [MODE_W-1:0] MODE_WORD  = 4'd2;
  localparam logic [MODE_W-1:0] MODE_DUMP  = 4'd3;
  localparam logic [MODE_W-1:0] MODE_EAT   = 4'd4;
  localparam logic [MODE_W-1:0] MODE_CR    = 4'd5;
  localparam logic [MODE_W-1:0] MODE_LF    = 4'd6;
  localparam logic [MODE_W-1:0] MODE_ECR1  = 4'd7;   // closing CRLF pair at end of text
  localparam logic [MODE_W-1:0] MODE_ELF1  = 4'd8;
  localparam logic [MODE_W-1:0] MODE_ECR2  = 4'd9;
  localparam logic [MODE_W-1:0] MODE_ELF2  = 4'd10;

  logic [MODE_W-1:0] mode_q, mode_d, anm_q, anm_d, awm_q, awm_d;
  logic [WlW-1:0]    wl_q, wl_d, idx_q, idx_d, wl_inc;
  logic [LINE_W-1:0] ll_q, ll_d;
  logic              fin_q, fin_d, eot_q, eot_d;
  logic [BYTE_W-1:0] store_q [MaxColumn];
  logic [BYTE_W-1:0] rd_data_q;
  logic [AddrW-1:0]  rd_addr;
  logic              we, run, consume;
  logic              word_full, word_over, line_full;

  assign wl_inc    = wl_q + WlW'(1);
  assign word_full = (LINE_W'(wl_inc) >= LINE_W'(col_i));
  assign word_over = ((LINE_W+1)'(wl_q) + (LINE_W+1)'(ll_q)) > (LINE_W+1)'(col_i);
  assign line_full = (ll_q >= LINE_W'(col_i));

  // one step of the mode sequencer per cycle while the output stage is not busy
  always_comb begin
    mode_d  = mode_q;
    anm_d   = anm_q;
    awm_d   = awm_q;
    wl_d    = wl_q;
    ll_d    = ll_q;
    idx_d   = idx_q;
    fin_d   = fin_q;
    eot_d   = eot_q;
    we      = 1'b0;
    consume = 1'b0;
    pop_o   = 1'b0;
    req_o   = '0;
    run     = !stat_i.busy && (eot_q || head_v_i);

    if (fin_q) begin
      pop_o = head_v_i;  // drop everything after end of text
    end else if (run) begin
      if (!eot_q && head_i.eot) begin
        pop_o  = 1'b1;
        mode_d = MODE_DUMP;
        eot_d  = 1'b1;
      end else begin
        case (mode_q)
          MODE_WS_CR: begin
            consume = head_i.lf;
            mode_d  = MODE_CR;
            anm_d   = MODE_WS;
          end
          MODE_WORD: begin
            if (!head_i.blank && !head_i.nul) begin
              if (wl_q < WlMax) begin
                we   = 1'b1;
                wl_d = wl_inc;
              end
              consume = 1'b1;
              if (word_full) begin
                mode_d = MODE_CR;
                anm_d  = MODE_DUMP;
                awm_d  = MODE_WORD;
              end
            end else begin
              if (word_over) begin
                mode_d = MODE_CR;
                anm_d  = MODE_DUMP;
              end else begin
                mode_d = MODE_DUMP;
              end
              awm_d = MODE_WS;
            end
          end
          MODE_DUMP: begin
            if (idx_q == wl_q) begin
              ll_d   = ll_q + LINE_W'(wl_q);
              wl_d   = '0;
              idx_d  = '0;
              mode_d = eot_q ? MODE_ECR1 : awm_q;
            end else if (stat_i.emit_ok) begin
              req_o.emit = 1'b1;
              req_o.data = rd_data_q;
              idx_d      = idx_q + WlW'(1);
            end
          end
          MODE_EAT: begin
            if (head_i.blank) begin
              consume = 1'b1;
            end else begin
              mode_d = MODE_WS;  // whitespace eating always hands back to scanning
            end
          end
          MODE_CR: begin
            if (stat_i.emit_ok) begin
              req_o.emit = 1'b1;
              req_o.data = CH_CR;
              ll_d       = '0;
              mode_d     = MODE_LF;
            end
          end
          MODE_LF: begin
            if (stat_i.emit_ok) begin
              req_o.emit = 1'b1;
              req_o.data = CH_LF;
              mode_d     = anm_q;
            end
          end
          MODE_ECR1, MODE_ECR2: begin
            if (stat_i.emit_ok) begin
              req_o.emit = 1'b1;
              req_o.data = CH_CR;
              mode_d     = (mode_q == MODE_ECR1) ? MODE_ELF1 : MODE_ELF2;
            end
          end
          MODE_ELF1: begin
            if (stat_i.emit_ok) begin
              req_o.emit = 1'b1;
              req_o.data = CH_LF;
              mode_d     = MODE_ECR2;
            end
          end
          MODE_ELF2: begin
            if (stat_i.emit_ok) begin
              req_o.emit  = 1'b1;
              req_o.data  = CH_LF;
              req_o.close = 1'b1;
              ll_d        = '0;
              fin_d       = 1'b1;
              eot_d       = 1'b0;
              mode_d      = MODE_WS;
              anm_d       = MODE_WS;
              awm_d       = MODE_WS;
            end
          end
          default: begin
            // scanning whitespace; unknown codes land here too
            mode_d = MODE_WS;
            if (head_i.cr) begin
              mode_d  = MODE_WS_CR;
              consume = 1'b1;
            end else if (head_i.lf) begin
              mode_d  = MODE_CR;
              anm_d   = MODE_WS;
              consume = 1'b1;
            end else if (head_i.blank) begin
              if (line_full) begin
                mode_d = MODE_CR;
                anm_d  = MODE_EAT;
              end else if (stat_i.emit_ok) begin
                req_o.emit = 1'b1;
                req_o.data = head_i.data;
                ll_d       = ll_q + LINE_W'(1);
                consume    = 1'b1;
              end
            end else if (head_i.nul) begin
              consume = 1'b1;
            end else begin
              wl_d   = '0;
              mode_d = MODE_WORD;
            end
          end
        endcase
      end
    end

    if (consume) begin
      pop_o       = 1'b1;
      req_o.close = 1'b1;
    end
  end

  // next dump address; past the store only on the final read, which is unused
  assign rd_addr = (idx_d < WlMax) ? idx_d[AddrW-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_WS;
      anm_q  <= MODE_WS;
      awm_q  <= MODE_WS;
      wl_q   <= '0;
      ll_q   <= '0;
      idx_q  <= '0;
      fin_q  <= 1'b0;
      eot_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      anm_q  <= anm_d;
      awm_q  <= awm_d;
      wl_q   <= wl_d;
      ll_q   <= ll_d;
      idx_q  <= idx_d;
      fin_q  <= fin_d;
      eot_q  <= eot_d;
    end
  end

  // word store: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[wl_q[AddrW-1:0]] <= head_i.data;
    end
    rd_data_q <= store_q[rd_addr];
  end

`ifndef SYNTHESIS
  a_emit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_o.emit |-> stat_i.emit_ok)
    else $error("byte emitted while output stage full");
  a_busy_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.busy |-> !req_o.emit && !req_o.close)
    else $error("sequencer ran while a closed step drains");
  a_wl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wl_q <= WlMax)
    else $error("word length beyond store depth");
  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_DUMP) |-> (idx_q == '0))
    else $error("dump index not cleared outside dump");
  a_fin_eot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fin_q) |-> !eot_q && $past(req_o.close))
    else $error("finish without closing CRLF");
`endif

endmodule

@@ rtl/core/twwc_out.sv @@
`timescale 1ns / 1ps

module twwc_out import twwc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  emit_req_t         req_i,
  output out_stat_t         stat_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [BYTE_W-1:0] m_axis_tdata,   // [7:0] out_byte
  output logic              m_axis_tlast    // last_out
);

  // The newest byte waits in hold until it is known whether it ends its step.
  logic              hold_v_q, hold_fin_q;
  logic [BYTE_W-1:0] hold_q;
  logic              out_v_q, out_last_q;
  logic [BYTE_W-1:0] out_q;
  logic              out_free, push_mid, push_last;

  assign out_free       = !out_v_q || m_axis_tready;
  assign stat_o.emit_ok = !hold_v_q || out_free;
  assign stat_o.busy    = hold_v_q && hold_fin_q;
  assign push_mid       = req_i.emit && hold_v_q;
  assign push_last      = stat_o.busy && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q   <= 1'b0;
      hold_fin_q <= 1'b0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      if (req_i.emit) begin
        hold_v_q   <= 1'b1;
        hold_fin_q <= req_i.close;
      end else if (req_i.close && hold_v_q) begin
        hold_fin_q <= 1'b1;
      end else if (push_last) begin
        hold_v_q   <= 1'b0;
        hold_fin_q <= 1'b0;
      end
      if (push_mid || push_last) begin
        out_v_q    <= 1'b1;
        out_last_q <= push_last;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.emit) begin
      hold_q <= req_i.data;
    end
    if (push_mid || push_last) begin
      out_q <= hold_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tlast  = out_last_q;

endmodule

@@ rtl/core/text_word_wrap_crlf.sv @@
`timescale 1ns / 1ps

// Greedy word wrap with CR/LF normalisation for a mail body.
// Input stream: one text byte per beat in s_axis_tdata; s_axis_tlast marks end
// of text (the byte is then ignored), which flushes the pending word and
// appends two CRLFs. Beats after that are taken and dropped until reset.
// Output stream: one byte per beat; m_axis_tlast flags the final byte caused
// by an input beat. Input beats that cause nothing give no output beat.
// Config: cfg_we_i writes cfg_wdata_i into the wrap column (0 acts as 1, above
// MaxColumn as MaxColumn); write only while the block is idle.
// Timing: a two-entry queue decouples the classifier from the mode sequencer.
// The sequencer takes one step a cycle while its output stage is not busy and
// emits at most one byte a cycle; a word flush reads the word store one byte
// per step, and an inserted CRLF emits CR then LF. The last byte of a beat
// waits in the hold register until it is known to be last, then moves to the
// output register that drives the output stream.
// Stall: m_axis_tready low stalls each emitting step once the output stage is
// full; s_axis_tready then drops when the queue fills. No data is lost.
// Reset: column 60, modes to whitespace scan, counts cleared; the word store
// is not cleared and needs no clearing pass.

module text_word_wrap_crlf import twwc_pkg::*; #(
  parameter int unsigned MaxColumn = MAX_COLUMN
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [COL_W-1:0]  cfg_wdata_i,    // column_break
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] in_byte
  input  logic              s_axis_tlast,   // end_of_text
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [BYTE_W-1:0] m_axis_tdata,   // [7:0] out_byte
  output logic              m_axis_tlast    // last_out
);

  logic [COL_W-1:0] col_q, col_eff;
  item_t            head;
  logic             head_v, pop;
  emit_req_t        req;
  out_stat_t        stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= COL_RESET;
    end else if (cfg_we_i) begin
      col_q <= cfg_wdata_i;
    end
  end

  // clamp the column into 1..MaxColumn
  always_comb begin
    if (col_q == '0) begin
      col_eff = COL_W'(1);
    end else if (col_q > COL_W'(MaxColumn)) begin
      col_eff = COL_W'(MaxColumn);
    end else begin
      col_eff = col_q;
    end
  end

  twwc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .head_o        (head),
    .head_v_o      (head_v),
    .pop_i         (pop)
  );

  twwc_back #(
    .MaxColumn (MaxColumn)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .col_i    (col_eff),
    .head_i   (head),
    .head_v_i (head_v),
    .pop_o    (pop),
    .req_o    (req),
    .stat_i   (stat)
  );

  twwc_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .stat_o        (stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
